@@ hdl/fsms_pkg.sv @@
// Package for the folded substring match scorer.
// Holds the operation codes, the queue entry type, score constants and the
// case-folding function. Depends on nothing.
package fsms_pkg;

  localparam int OP_W    = 2;
  localparam int CH_W    = 8;
  localparam int SCORE_W = 11;
  localparam int POS_W   = 16;
  localparam int OFF_W   = 8;

  // Operation carried by each input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_QUERY     = 2'd0,
    OP_PRIMARY   = 2'd1,
    OP_SECONDARY = 2'd2,
    OP_FINISH    = 2'd3
  } op_t;

  // One classified entry between the front and the back.
  typedef struct packed {
    op_t             op;
    logic [CH_W-1:0] ch;
  } queue_item_t;

  localparam logic [POS_W-1:0] POS_MAX    = 16'hFFFF;
  localparam logic [OFF_W-1:0] OFFSET_CAP = 8'd200;

  localparam logic signed [SCORE_W-1:0] SCORE_EXACT          = 11'sd1000;
  localparam logic signed [SCORE_W-1:0] SCORE_PRIMARY_BASE   = 11'sd800;
  localparam logic signed [SCORE_W-1:0] SCORE_SECONDARY_BASE = 11'sd500;
  localparam logic signed [SCORE_W-1:0] SCORE_EMPTY          = 11'sd100;
  localparam logic signed [SCORE_W-1:0] SCORE_NONE           = -11'sd1;

  // Fold ASCII upper-case letters to lower case; other bytes pass unchanged.
  function automatic logic [CH_W-1:0] fold_char(input logic [CH_W-1:0] c);
    logic [CH_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

@@ hdl/fsms_if.sv @@
// Valid/ready channel interfaces for the scorer's input and result streams.
// Depends on fsms_pkg for field widths.
interface fsms_in_if import fsms_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  logic [CH_W-1:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

interface fsms_out_if import fsms_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      query_overflow;

  modport source (output valid, output score, output query_overflow, input ready);
  modport sink   (input valid, input score, input query_overflow, output ready);
endinterface

@@ hdl/fsms_front.sv @@
// Front end of the scorer: accepts input transactions, folds the character
// and classifies the operation into a queue entry. Depends on fsms_pkg, fsms_if.
module fsms_front import fsms_pkg::*; (
  fsms_in_if.sink     in_chan,
  input  logic        queue_full,
  output logic        push,
  output queue_item_t push_item
);

  // Accept whenever the queue has room.
  assign in_chan.ready = !queue_full;
  assign push          = in_chan.valid && !queue_full;

  // Classify the operation and fold the character once, here.
  always_comb begin
    push_item.op = op_t'(in_chan.op);
    push_item.ch = fold_char(in_chan.ch);
  end

endmodule

@@ hdl/fsms_queue.sv @@
// Two-entry queue that decouples the front end from the matching back end.
// Depends on fsms_pkg for the entry type.
module fsms_queue import fsms_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  queue_item_t push_item,
  input  logic        pop,
  output logic        full,
  output logic        empty,
  output queue_item_t head
);

  queue_item_t entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = entry_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hdl/fsms_back.sv @@
// Back end of the scorer: keeps the query and text window as shift lines,
// compares them in parallel, records first matches and registers the score.
// Depends on fsms_pkg and fsms_if.
module fsms_back import fsms_pkg::*; #(
  parameter int QMAX = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        queue_empty,
  input  queue_item_t head,
  output logic        pop,
  fsms_out_if.source  out_chan
);

  localparam int LEN_W = $clog2(QMAX + 1);

  // The query is held newest first, so entry i lines up with window entry i.
  logic [CH_W-1:0]           query_r [QMAX];
  logic [CH_W-1:0]           window_r [QMAX];
  logic [CH_W-1:0]           window_nxt [QMAX];
  logic [LEN_W-1:0]          len_r, len_nxt;
  logic [POS_W-1:0]          ppos_r, ppos_nxt, spos_r, spos_nxt;
  logic                      pfound_r, pfound_nxt, sfound_r, sfound_nxt;
  logic [OFF_W-1:0]          poff_r, poff_nxt, soff_r, soff_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SCORE_W-1:0] out_score_r, out_score_nxt;
  logic                      out_ovf_r, out_ovf_nxt;

  logic                      is_query, is_text, is_primary, is_finish;
  logic                      query_push;
  logic [QMAX-1:0]           char_eq;
  logic                      window_match;
  logic [POS_W-1:0]          sel_pos;
  logic                      sel_found;
  logic [POS_W:0]            pos_inc;
  logic [POS_W:0]            start;
  logic                      hit;
  logic [OFF_W-1:0]          hit_off;
  logic signed [SCORE_W-1:0] score_calc;

  assign is_query   = (head.op == OP_QUERY);
  assign is_primary = (head.op == OP_PRIMARY);
  assign is_text    = (head.op == OP_PRIMARY) || (head.op == OP_SECONDARY);
  assign is_finish  = (head.op == OP_FINISH);

  // A finish needs the result register free or draining this cycle.
  assign pop = !queue_empty && (!is_finish || !out_valid_r || out_chan.ready);
  assign query_push = pop && is_query && (len_r < LEN_W'(QMAX));

  // Shifted window and the parallel compare against the stored query.
  always_comb begin
    window_nxt[0] = head.ch;
    for (int i = 1; i < QMAX; i++) begin
      window_nxt[i] = window_r[i-1];
    end
    for (int i = 0; i < QMAX; i++) begin
      char_eq[i] = (LEN_W'(i) >= len_r) || (window_nxt[i] == query_r[i]);
    end
    window_match = &char_eq;
  end

  // First-occurrence test for whichever text this character belongs to.
  always_comb begin
    sel_pos   = is_primary ? ppos_r : spos_r;
    sel_found = is_primary ? pfound_r : sfound_r;
    pos_inc   = {1'b0, sel_pos} + 17'd1;
    start     = pos_inc - (POS_W+1)'(len_r);
    hit       = !sel_found && (len_r != '0) && (pos_inc >= (POS_W+1)'(len_r))
                && window_match;
    hit_off   = (start < (POS_W+1)'(OFFSET_CAP)) ? start[OFF_W-1:0] : OFFSET_CAP;
  end

  // Score from the current match state.
  always_comb begin
    priority if (len_r == '0) begin
      score_calc = SCORE_EMPTY;
    end else if (pfound_r) begin
      score_calc = (poff_r == '0) ? SCORE_EXACT
                 : SCORE_PRIMARY_BASE - $signed({3'b000, poff_r});
    end else if (sfound_r) begin
      score_calc = SCORE_SECONDARY_BASE - $signed({3'b000, soff_r});
    end else begin
      score_calc = SCORE_NONE;
    end
  end

  // Next state of the match bookkeeping and the result register.
  always_comb begin
    len_nxt       = len_r;
    ppos_nxt      = ppos_r;
    spos_nxt      = spos_r;
    pfound_nxt    = pfound_r;
    sfound_nxt    = sfound_r;
    poff_nxt      = poff_r;
    soff_nxt      = soff_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_score_nxt = out_score_r;
    out_ovf_nxt   = out_ovf_r;
    if (pop) begin
      unique case (head.op)
        OP_QUERY: begin
          if (query_push) begin
            len_nxt = len_r + LEN_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        OP_PRIMARY: begin
          if (hit) begin
            pfound_nxt = 1'b1;
            poff_nxt   = hit_off;
          end
          if (ppos_r != POS_MAX) begin
            ppos_nxt = pos_inc[POS_W-1:0];
          end
        end
        OP_SECONDARY: begin
          if (hit) begin
            sfound_nxt = 1'b1;
            soff_nxt   = hit_off;
          end
          if (spos_r != POS_MAX) begin
            spos_nxt = pos_inc[POS_W-1:0];
          end
        end
        OP_FINISH: begin
          out_valid_nxt = 1'b1;
          out_score_nxt = score_calc;
          out_ovf_nxt   = ovf_r;
          len_nxt       = '0;
          ppos_nxt      = '0;
          spos_nxt      = '0;
          pfound_nxt    = 1'b0;
          sfound_nxt    = 1'b0;
          poff_nxt      = '0;
          soff_nxt      = '0;
          ovf_nxt       = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ppos_r      <= '0;
      spos_r      <= '0;
      pfound_r    <= 1'b0;
      sfound_r    <= 1'b0;
      poff_r      <= '0;
      soff_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ppos_r      <= ppos_nxt;
      spos_r      <= spos_nxt;
      pfound_r    <= pfound_nxt;
      sfound_r    <= sfound_nxt;
      poff_r      <= poff_nxt;
      soff_r      <= soff_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Shift lines and result payload carry no reset.
  always_ff @(posedge clk) begin
    if (query_push) begin
      query_r[0] <= head.ch;
      for (int i = 1; i < QMAX; i++) begin
        query_r[i] <= query_r[i-1];
      end
    end
    if (pop && is_text) begin
      window_r <= window_nxt;
    end
    out_score_r <= out_score_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.score          = out_score_r;
  assign out_chan.query_overflow = out_ovf_r;

  // The stored query never grows past its capacity.
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(QMAX))
    else $error("query length exceeds capacity");

  // A consumed finish clears the state and presents a result.
  a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && is_finish |=> out_valid_r && len_r == '0 && !pfound_r && !sfound_r)
    else $error("finish did not clear state or present a result");

  // A found match is kept until a finish.
  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    pfound_r && !(pop && is_finish) |=> pfound_r)
    else $error("primary match lost before finish");

  // Recorded offsets stay within the cap.
  a_offset_cap: assert property (@(posedge clk) disable iff (!rst_n)
    poff_r <= OFFSET_CAP && soff_r <= OFFSET_CAP)
    else $error("match offset above cap");

  // An unaccepted result must not be overwritten.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |=> out_valid_r && $stable(out_score_r))
    else $error("pending result changed before it was taken");

endmodule

@@ hdl/folded_substring_match_scorer.sv @@
// Channel   | Dir | Fields                         | Handshake
// in_chan   | in  | op[1:0], ch[7:0]               | valid/ready
// out_chan  | out | score[10:0] signed, query_overflow | valid/ready
//
// One input transaction is taken per cycle while the queue has room; query and
// text characters never stall the back end, thanks to the parallel window compare.
// A finish transaction yields its score in the cycle after it leaves the queue and
// waits only while the previous score is still unaccepted in the result register.
// A two-entry queue lets the input side keep accepting during such a stall.
// Reset is synchronous, active low, and clears all match state; the query and
// window shift lines need no clearing pass.
//
// Top level of the folded substring match scorer: front end, queue and back end.
// Depends on fsms_pkg, fsms_if, fsms_front, fsms_queue and fsms_back.
module folded_substring_match_scorer import fsms_pkg::*; #(
  parameter int QMAX = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  fsms_in_if.sink    in_chan,
  fsms_out_if.source out_chan
);

  logic        queue_full;
  logic        queue_empty;
  logic        push;
  logic        pop;
  queue_item_t push_item;
  queue_item_t head;

  // Accept and classify.
  fsms_front u_front (
    .in_chan    (in_chan),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  // Decoupling queue.
  fsms_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (queue_full),
    .empty     (queue_empty),
    .head      (head)
  );

  // Match and score.
  fsms_back #(
    .QMAX (QMAX)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_chan    (out_chan)
  );

endmodule
